// ----- hdl/swr_pkg.sv -----
// Shared types and constants for the stream wildcard replace unit.
// Used by the window cells, the output cells and the top level; no dependencies.
package swr_pkg;

    // Default sizes for the top-level parameters.
    localparam int PATTERN_MAX_DEF     = 8;
    localparam int REPLACEMENT_MAX_DEF = 8;

    // Byte slots in the 64-bit pattern and replacement registers.
    localparam int REG_BYTES = 8;

    // Pattern byte that matches any text byte ('?').
    localparam logic [7:0] WILDCARD = 8'h3F;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_ALL        = 3'd4;

    // One result beat as it travels down the output chain.
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } swr_entry_t;

endpackage

// ----- hdl/swr_win_cell.sv -----
// One byte cell of the search window, with its own compare against the pattern.
// Depends on swr_pkg for the wildcard code.
module swr_win_cell #(
    parameter int CELL_ID = 0,
    parameter int FILL_W  = 4
) (
    input  logic              clk,
    input  logic              accept,
    input  logic              shift,
    input  logic [FILL_W-1:0] fill,
    input  logic [FILL_W-1:0] plen,
    input  logic [7:0]        text_byte,
    input  logic [7:0]        pattern_byte,
    input  logic [7:0]        right_byte,
    output logic [7:0]        cur_byte,
    output logic              hit
);
    import swr_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       in_use;

    // The new byte lands in the cell that the fill count points at.
    always_comb
    begin
        cur_byte = (fill == FILL_W'(CELL_ID)) ? text_byte : byte_reg;
        in_use   = (FILL_W'(CELL_ID) < plen);
        hit      = !in_use || (pattern_byte == WILDCARD) || (cur_byte == pattern_byte);
    end

    // On a pass-through the window moves one cell toward the oldest end.
    always_comb
    begin
        if (accept)
        begin
            byte_next = shift ? right_byte : cur_byte;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// ----- hdl/swr_out_cell.sv -----
// One slot of the output chain: loads a result beat or takes its right neighbor's.
// Depends on swr_pkg for the beat type.
module swr_out_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                take,
    input  swr_pkg::swr_entry_t load_entry,
    input  logic                load_occ,
    input  swr_pkg::swr_entry_t right_entry,
    input  logic                right_occ,
    output swr_pkg::swr_entry_t entry,
    output logic                occ
);
    import swr_pkg::*;

    swr_entry_t entry_reg;
    swr_entry_t entry_next;
    logic       occ_reg;
    logic       occ_next;

    always_comb
    begin
        priority if (load)
        begin
            entry_next = load_entry;
            occ_next   = load_occ;
        end
        else if (take)
        begin
            entry_next = right_entry;
            occ_next   = right_occ;
        end
        else
        begin
            entry_next = entry_reg;
            occ_next   = occ_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign occ   = occ_reg;

endmodule

// ----- hdl/stream_wildcard_replace_unit.sv -----
// Stream wildcard replace unit: top level with the window chain and output chain.
// Depends on swr_pkg, swr_win_cell and swr_out_cell.
// The first result beat of an input byte is offered in the cycle after the byte is accepted.
// Throughput: one input byte per cycle while each byte yields at most one result beat and
// out_stall is low; input stalls while a replacement or flush has more than one beat left.
// Reset (rst_n, asynchronous): the window empties, replacing is re-armed, registers take defaults.
module stream_wildcard_replace_unit #(
    parameter int PATTERN_MAX     = swr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACEMENT_MAX = swr_pkg::REPLACEMENT_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_write,
    input  logic [swr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         text_byte,
    input  logic                               string_last,
    // Output channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         out_byte,
    output logic                               byte_valid,
    output logic                               run_last,
    output logic                               string_end
);
    import swr_pkg::*;

    // The window never holds more than the register's eight pattern bytes, and a
    // step never yields more beats than the window or the replacement can supply.
    localparam int WIN_CELLS = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int REP_CELLS = (REPLACEMENT_MAX < REG_BYTES) ? REPLACEMENT_MAX : REG_BYTES;
    localparam int OUT_DEPTH = (WIN_CELLS > REP_CELLS) ? WIN_CELLS : REP_CELLS;
    localparam int FILL_W    = $clog2(WIN_CELLS + 1);
    localparam int RLEN_W    = $clog2(REP_CELLS + 1);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    // Configuration registers. Lengths are stored already clamped to their legal range.
    logic [CFG_DATA_W-1:0] pattern_reg;
    logic [FILL_W-1:0]     plen_reg;
    logic [CFG_DATA_W-1:0] repl_reg;
    logic [RLEN_W-1:0]     rlen_reg;
    logic                  replace_all_reg;

    // Window bookkeeping.
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              still_reg;
    logic              still_next;

    // Handshake.
    logic in_fire;
    logic out_take;
    logic deep_busy;

    // Step decision.
    logic [FILL_W-1:0] fill_inc;
    logic              full;
    logic              match;
    logic              do_repl;
    logic              shift;
    logic              empty_repl;
    logic [CNT_W-1:0]  count;

    logic [3:0]        plen_raw;
    logic [FILL_W-1:0] plen_clamp;
    logic [3:0]        rlen_raw;
    logic [RLEN_W-1:0] rlen_clamp;

    logic [7:0]           cur_bytes [WIN_CELLS];
    logic [WIN_CELLS-1:0] hits;

    logic [7:0]     win_view  [OUT_DEPTH];
    logic [7:0]     repl_view [OUT_DEPTH];
    swr_entry_t     load_entries [OUT_DEPTH];
    logic           load_occs    [OUT_DEPTH];
    swr_entry_t     entries      [OUT_DEPTH];
    logic [OUT_DEPTH-1:0] occ_vec;

    //------------------------------------------------------------------
    // Configuration. A pattern length write is dropped while the window
    // still holds bytes of an unfinished string, so an open window is
    // always judged against the length it was filled for.
    //------------------------------------------------------------------
    always_comb
    begin
        plen_raw = cfg_data[3:0];
        rlen_raw = cfg_data[3:0];

        if (plen_raw == 4'd0)
        begin
            plen_clamp = FILL_W'(1);
        end
        else if (plen_raw > 4'(WIN_CELLS))
        begin
            plen_clamp = FILL_W'(WIN_CELLS);
        end
        else
        begin
            plen_clamp = FILL_W'(plen_raw);
        end

        if (rlen_raw > 4'(REP_CELLS))
        begin
            rlen_clamp = RLEN_W'(REP_CELLS);
        end
        else
        begin
            rlen_clamp = RLEN_W'(rlen_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            plen_reg        <= FILL_W'(1);
            repl_reg        <= '0;
            rlen_reg        <= '0;
            replace_all_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES:
                begin
                    pattern_reg <= cfg_data;
                end
                CFG_PATTERN_LENGTH:
                begin
                    if (fill_reg == '0)
                    begin
                        plen_reg <= plen_clamp;
                    end
                end
                CFG_REPLACEMENT_BYTES:
                begin
                    repl_reg <= cfg_data;
                end
                CFG_REPLACEMENT_LENGTH:
                begin
                    rlen_reg <= rlen_clamp;
                end
                CFG_REPLACE_ALL:
                begin
                    replace_all_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Handshake. A new byte is taken whenever the output chain will be
    // empty after this edge: either it is empty, or its only beat is being
    // taken now. So a one-beat byte flows every cycle while out_stall is low.
    //------------------------------------------------------------------
    generate
        if (OUT_DEPTH > 1)
        begin : g_deep
            assign deep_busy = |occ_vec[OUT_DEPTH-1:1];
        end
        else
        begin : g_shallow
            assign deep_busy = 1'b0;
        end
    endgenerate

    assign out_take = occ_vec[0] & ~out_stall;
    assign in_stall = deep_busy | (occ_vec[0] & out_stall);
    assign in_fire  = in_valid & ~in_stall;

    //------------------------------------------------------------------
    // Window chain. Each cell holds one byte, compares it with its pattern
    // byte, and on a pass-through takes the byte of its right neighbor.
    //------------------------------------------------------------------
    generate
        for (genvar k = 0; k < WIN_CELLS; k++)
        begin : g_win
            logic [7:0] right_byte;

            if (k < WIN_CELLS - 1)
            begin : g_mid
                assign right_byte = cur_bytes[k+1];
            end
            else
            begin : g_end
                assign right_byte = 8'h00;
            end

            swr_win_cell #(
                .CELL_ID (k),
                .FILL_W  (FILL_W)
            ) u_cell (
                .clk          (clk),
                .accept       (in_fire),
                .shift        (shift),
                .fill         (fill_reg),
                .plen         (plen_reg),
                .text_byte    (text_byte),
                .pattern_byte (pattern_reg[8*k +: 8]),
                .right_byte   (right_byte),
                .cur_byte     (cur_bytes[k]),
                .hit          (hits[k])
            );
        end
    endgenerate

    //------------------------------------------------------------------
    // Step decision. The window is always shorter than the pattern before
    // a byte arrives, so with the new byte it is either just full or not.
    // A full window that matches (while replacing is armed) becomes the
    // replacement and empties. Otherwise its oldest byte leaves. At the end
    // of a string everything still in the window follows, which means the
    // beats of a non-matching step are always a prefix of the window.
    //------------------------------------------------------------------
    always_comb
    begin
        fill_inc   = fill_reg + FILL_W'(1);
        full       = (fill_inc == plen_reg);
        match      = &hits;
        do_repl    = full & still_reg & match;
        shift      = full & ~do_repl;
        empty_repl = do_repl && (rlen_reg == '0);

        priority if (do_repl)
        begin
            count = (empty_repl && string_last) ? CNT_W'(1) : CNT_W'(rlen_reg);
        end
        else if (string_last)
        begin
            count = CNT_W'(fill_inc);
        end
        else if (full)
        begin
            count = CNT_W'(1);
        end
        else
        begin
            count = '0;
        end

        priority if (do_repl || string_last)
        begin
            fill_next = '0;
        end
        else if (full)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_inc;
        end

        priority if (string_last)
        begin
            still_next = 1'b1;
        end
        else if (do_repl)
        begin
            still_next = replace_all_reg;
        end
        else
        begin
            still_next = still_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            still_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            fill_reg  <= fill_next;
            still_reg <= still_next;
        end
    end

    //------------------------------------------------------------------
    // Beats of the step, one per output cell. An empty replacement at the
    // end of a string still sends one end marker with no data.
    //------------------------------------------------------------------
    generate
        for (genvar k = 0; k < OUT_DEPTH; k++)
        begin : g_load
            if (k < WIN_CELLS)
            begin : g_wv
                assign win_view[k] = cur_bytes[k];
            end
            else
            begin : g_wz
                assign win_view[k] = 8'h00;
            end

            if (k < REP_CELLS)
            begin : g_rv
                assign repl_view[k] = repl_reg[8*k +: 8];
            end
            else
            begin : g_rz
                assign repl_view[k] = 8'h00;
            end

            always_comb
            begin
                load_occs[k]                = (CNT_W'(k) < count);
                load_entries[k].data        = do_repl ? (empty_repl ? 8'h00 : repl_view[k])
                                                      : win_view[k];
                load_entries[k].byte_valid  = ~empty_repl;
                load_entries[k].run_last    = (CNT_W'(k + 1) == count);
                load_entries[k].string_end  = (CNT_W'(k + 1) == count) & string_last;
            end
        end
    endgenerate

    //------------------------------------------------------------------
    // Output chain. Cell 0 faces the port; the others move one place
    // toward it each time a beat is taken.
    //------------------------------------------------------------------
    generate
        for (genvar k = 0; k < OUT_DEPTH; k++)
        begin : g_out
            swr_entry_t right_entry;
            logic       right_occ;

            if (k < OUT_DEPTH - 1)
            begin : g_mid
                assign right_entry = entries[k+1];
                assign right_occ   = occ_vec[k+1];
            end
            else
            begin : g_end
                assign right_entry = '0;
                assign right_occ   = 1'b0;
            end

            swr_out_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .load        (in_fire),
                .take        (out_take),
                .load_entry  (load_entries[k]),
                .load_occ    (load_occs[k]),
                .right_entry (right_entry),
                .right_occ   (right_occ),
                .entry       (entries[k]),
                .occ         (occ_vec[k])
            );
        end
    endgenerate

    assign out_valid  = occ_vec[0];
    assign out_byte   = entries[0].data;
    assign byte_valid = entries[0].byte_valid;
    assign run_last   = entries[0].run_last;
    assign string_end = entries[0].string_end;

`ifndef SYNTHESIS
    // The window is always emptied or trimmed before it outgrows the pattern.
    a_fill_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < plen_reg)
        else $error("window fill reached the pattern length");

    // Occupied output cells form one unbroken run starting at the port.
    a_out_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec & (occ_vec + OUT_DEPTH'(1))) == '0)
        else $error("gap in the output chain");

    // The end of a string always leaves an empty window behind.
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && string_last |=> fill_reg == '0)
        else $error("window not empty after the end of a string");

    // The final beat of a string is also the final beat of its step.
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end beat without run_last");
`endif

endmodule
